[rtl/core/fsmu_pkg.sv]
// Shared types and constants for the floating-point store-multiple unit.
// Depends on nothing; imported by every module of the block.
package fsmu_pkg;

   localparam int NUM_REGS_DEF = 32;
   localparam int MAX_DOUBLES  = 16;

   localparam logic [1:0] OP_LOAD_SINGLE = 2'd0;
   localparam logic [1:0] OP_LOAD_DOUBLE = 2'd1;
   localparam logic [1:0] OP_EXECUTE     = 2'd2;

   localparam int CSR_ADDR_W = 3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] instruction;
      logic [4:0]  reg_index;
      logic [63:0] reg_value;
      logic [31:0] base_value;
      logic        cond_pass;
   } fsmu_req_type;

   typedef struct packed {
      logic        mem_valid;
      logic [31:0] mem_address;
      logic [31:0] mem_data;
      logic        base_write;
      logic [31:0] base_new;
      logic        error;
      logic        last;
   } fsmu_rsp_type;

   typedef struct packed {
      logic accept;
      logic emit_special;
      logic begin_list;
      logic rd_issue;
      logic emit_first;
      logic emit_second;
   } fsmu_cmd_type;

   typedef struct packed {
      logic special;
      logic dbl;
      logic more;
   } fsmu_status_type;

endpackage

[rtl/core/fp_store_multiple_unit.sv]
// Top level of the floating-point store-multiple unit: APB register and submodule wiring.
// Depends on fsmu_pkg, fsmu_ctrl and fsmu_datapath.
//
// A register-load item (op 0 or 1) leaves busy low. An execute item holds busy while it
// runs and gives either a single status result or a list of words; the words come one
// per cycle, limited by the register file's registered read port. Each result is marked
// by rsp_strobe high for exactly one cycle; there is no back-pressure, so the receiver
// must take every word as it appears. The last word of an item has last set and carries
// the base write-back. Register file entries that were never loaded return undefined data.
module fp_store_multiple_unit
   import fsmu_pkg::*;
#(
   parameter int NUM_REGS = NUM_REGS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  fsmu_req_type          req_payload,
   output logic                  rsp_strobe,
   output fsmu_rsp_type          rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic            big_endian_ff, big_endian_in;
   fsmu_cmd_type    cmd;
   fsmu_status_type status;

   assign csr_pready = 1'b1;
   assign csr_prdata = {31'b0, big_endian_ff};

   always_comb begin
      big_endian_in = big_endian_ff;
      if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         big_endian_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
      end else begin
         big_endian_ff <= big_endian_in;
      end
   end

   fsmu_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .op     (req_payload.op),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   fsmu_datapath #(
      .NUM_REGS (NUM_REGS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req        (req_payload),
      .big_endian (big_endian_ff),
      .cmd        (cmd),
      .status     (status),
      .rsp        (rsp_payload),
      .rsp_strobe (rsp_strobe)
   );

endmodule

[rtl/core/fsmu_ctrl.sv]
// Sequencer for the store-multiple unit: steps decode, register reads and word emission.
// Depends on fsmu_pkg; drives fsmu_datapath through command and status structs.
module fsmu_ctrl
   import fsmu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [1:0]      op,
   input  fsmu_status_type status,
   output logic            busy,
   output fsmu_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_FETCH  = 3'd2;
   localparam logic [2:0] ST_EMIT_A = 3'd3;
   localparam logic [2:0] ST_EMIT_B = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = start;
            if (start && (op == OP_EXECUTE)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.special) begin
               cmd.emit_special = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               cmd.begin_list = 1'b1;
               state_in       = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_EMIT_A;
         end
         ST_EMIT_A: begin
            cmd.emit_first = 1'b1;
            if (status.dbl) begin
               state_in = ST_EMIT_B;
            end else if (status.more) begin
               cmd.rd_issue = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_B: begin
            cmd.emit_second = 1'b1;
            if (status.more) begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_EMIT_A;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/fsmu_datapath.sv]
// Datapath of the store-multiple unit: register files, decode, address and word output.
// Depends on fsmu_pkg; commanded by fsmu_ctrl.
module fsmu_datapath
   import fsmu_pkg::*;
#(
   parameter int NUM_REGS = NUM_REGS_DEF
)
(
   input  logic            clock,
   input  logic            reset,
   input  fsmu_req_type    req,
   input  logic            big_endian,
   input  fsmu_cmd_type    cmd,
   output fsmu_status_type status,
   output fsmu_rsp_type    rsp,
   output logic            rsp_strobe
);

   localparam int IDX_W = $clog2(NUM_REGS);
   localparam int CNT_W = $clog2(NUM_REGS + 1);

   logic [31:0] single_regs_ff [NUM_REGS];
   logic [63:0] double_regs_ff [NUM_REGS];
   logic [31:0] single_rd_ff;
   logic [63:0] double_rd_ff;

   logic [31:0] inst_ff;
   logic [31:0] base_ff;
   logic        cond_ff;

   logic [31:0]      addr_ff, addr_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] left_ff, left_in;
   fsmu_rsp_type     rsp_ff, rsp_in;
   logic             strobe_ff, strobe_in;

   logic        p_bit, u_bit, d_bit, w_bit, dbl;
   logic [3:0]  vd;
   logic [7:0]  imm8;
   logic [4:0]  first_reg;
   logic [7:0]  count;
   logic [8:0]  reg_end;
   logic [31:0] offset, base_next, start_addr;
   logic        skip, mode_err, legal, wb, down, len_err;
   logic        single_we, double_we, index_ok;
   logic [31:0] word_lo, word_hi;
   logic        last_first, last_second;

   assign p_bit = inst_ff[24];
   assign u_bit = inst_ff[23];
   assign d_bit = inst_ff[22];
   assign w_bit = inst_ff[21];
   assign vd    = inst_ff[15:12];
   assign dbl   = inst_ff[8];
   assign imm8  = inst_ff[7:0];

   assign skip     = ~cond_ff;
   assign mode_err = (p_bit == u_bit) & w_bit;
   assign legal    = (~p_bit & u_bit) | (p_bit & ~u_bit & w_bit);
   assign down     = p_bit & ~u_bit & w_bit;
   assign wb       = (~p_bit & u_bit & w_bit) | down;

   assign first_reg = dbl ? {d_bit, vd} : {vd, d_bit};
   assign count     = dbl ? {1'b0, imm8[7:1]} : imm8;
   assign reg_end   = {4'b0, first_reg} + {1'b0, count};
   assign len_err   = (dbl && (count > 8'(MAX_DOUBLES))) || (reg_end > 9'(NUM_REGS));

   assign offset     = {22'b0, imm8, 2'b00};
   assign base_next  = down ? (base_ff - offset) : (base_ff + offset);
   assign start_addr = down ? (base_ff - offset) : base_ff;

   assign status.special = skip | mode_err | ~legal | len_err | (count == 8'd0);
   assign status.dbl     = dbl;
   assign status.more    = (left_ff != '0);

   assign index_ok  = ({1'b0, req.reg_index} < 6'(NUM_REGS));
   assign single_we = cmd.accept && (req.op == OP_LOAD_SINGLE) && index_ok;
   assign double_we = cmd.accept && (req.op == OP_LOAD_DOUBLE) && index_ok;

   always_ff @(posedge clock) begin
      if (single_we) begin
         single_regs_ff[req.reg_index[IDX_W-1:0]] <= req.reg_value[31:0];
      end
      if (double_we) begin
         double_regs_ff[req.reg_index[IDX_W-1:0]] <= req.reg_value;
      end
      if (cmd.rd_issue) begin
         single_rd_ff <= single_regs_ff[ptr_ff];
         double_rd_ff <= double_regs_ff[ptr_ff];
      end
   end

   assign word_lo     = double_rd_ff[31:0];
   assign word_hi     = double_rd_ff[63:32];
   assign last_first  = ~dbl & (left_ff == '0);
   assign last_second = (left_ff == '0);

   always_comb begin
      addr_in   = addr_ff;
      ptr_in    = ptr_ff;
      left_in   = left_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;

      if (cmd.begin_list) begin
         addr_in = start_addr;
         ptr_in  = first_reg[IDX_W-1:0];
         left_in = count[CNT_W-1:0];
      end
      if (cmd.rd_issue) begin
         ptr_in  = ptr_ff + 1'b1;
         left_in = left_ff - 1'b1;
      end

      if (cmd.emit_special) begin
         strobe_in         = 1'b1;
         rsp_in            = '0;
         rsp_in.last       = 1'b1;
         rsp_in.error      = ~skip & (mode_err | (legal & len_err));
         rsp_in.base_write = ~skip & legal & ~len_err & wb;
         rsp_in.base_new   = rsp_in.base_write ? base_next : 32'd0;
      end

      if (cmd.emit_first || cmd.emit_second) begin
         strobe_in          = 1'b1;
         addr_in            = addr_ff + 32'd4;
         rsp_in             = '0;
         rsp_in.mem_valid   = 1'b1;
         rsp_in.mem_address = addr_ff;
         if (cmd.emit_first) begin
            rsp_in.last     = last_first;
            rsp_in.mem_data = ~dbl ? single_rd_ff : (big_endian ? word_hi : word_lo);
         end else begin
            rsp_in.last     = last_second;
            rsp_in.mem_data = big_endian ? word_lo : word_hi;
         end
         rsp_in.base_write = rsp_in.last & wb;
         rsp_in.base_new   = rsp_in.base_write ? base_next : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         inst_ff <= req.instruction;
         base_ff <= req.base_value;
         cond_ff <= req.cond_pass;
      end
      addr_ff <= addr_in;
      ptr_ff  <= ptr_in;
      left_ff <= left_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign rsp        = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule
